[hdl/emst_pkg.sv]
// Package for the Euclidean MST length block: beat types, sizes, FSM states.
// No dependencies.
package emst_pkg;

    localparam int MAX_POINTS = 256;
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int IDX_BITS   = $clog2(MAX_POINTS);
    localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int SQ_BITS    = 2 * DIFF_BITS + 1;
    localparam int SUM_BITS   = 41;
    localparam int RAD_BITS   = SQ_BITS + 2 * FRAC_BITS;
    localparam int ROOT_BITS  = (RAD_BITS + 1) / 2;
    localparam int RAD_PAD    = 2 * ROOT_BITS;

    typedef struct packed {
        logic signed [15:0] x_coord;
        logic signed [15:0] y_coord;
        logic               last_point;
    } in_beat_t;

    typedef struct packed {
        logic [40:0] total_length;
        logic        points_dropped;
    } out_beat_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT_RD,
        ST_INIT_WR,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_DONE
    } state_t;

endpackage

[hdl/euclidean_mst_length.sv]
// Top level of the Euclidean MST length block: point store, dense Prim, sum.
// Depends on emst_pkg and emst_sqrt.
//
//  channel | signals                    | handshake
//  --------+----------------------------+----------------------------------
//  points  | start, busy, points_in     | beat taken when start && !busy
//  result  | done, result               | one-cycle strobe, cannot stall
//
// Loading takes one point per cycle. After the closing point, Prim runs over
// N stored points: an init pass over the entries, then per added point a
// scan over the entries, the serial square root and an update pass over the
// entries, all bound by the single-port distance memory. busy is high from
// the closing beat until the result strobe.
// Reset clears the counters and control; stores need no clearing.
module euclidean_mst_length (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  emst_pkg::in_beat_t   points_in,
    output logic                 done,
    output emst_pkg::out_beat_t  result
);
    localparam int IB = emst_pkg::IDX_BITS;
    localparam int CB = emst_pkg::CNT_BITS;
    localparam int SB = emst_pkg::SQ_BITS;
    localparam int DB = emst_pkg::DIFF_BITS;
    localparam int CW = emst_pkg::COORD_BITS;
    localparam int NB = emst_pkg::SUM_BITS;

    // point stores and per-point nearest squared distance (with in-tree flag)
    logic signed [CW-1:0] px_mem [emst_pkg::MAX_POINTS];
    logic signed [CW-1:0] py_mem [emst_pkg::MAX_POINTS];
    logic [SB:0]          nd_mem [emst_pkg::MAX_POINTS];

    emst_pkg::state_t state_reg, state_next;
    logic [CB-1:0] count_reg, count_next;
    logic          drop_reg, drop_next;
    logic [CB-1:0] idx_reg, idx_next;        // entry walk
    logic [CB-1:0] added_reg, added_next;    // points in tree
    logic [IB-1:0] best_reg, best_next;
    logic [SB-1:0] best_d_reg, best_d_next;
    logic          found_reg, found_next;
    logic [NB-1:0] sum_reg, sum_next;
    logic signed [CW-1:0] bx_reg, bx_next, by_reg, by_next;

    logic          accept;
    logic          pwr, nwr;
    logic [IB-1:0] prd_addr, nd_addr, pwr_addr;
    logic signed [CW-1:0] prd_x, prd_y;
    logic [SB:0]   nd_rd, nd_wdata;
    logic          sq_go, sq_done;
    logic [emst_pkg::ROOT_BITS-1:0] sq_root;
    logic signed [DB-1:0] dx, dy;
    logic [DB-1:0] adx, ady;
    logic [2*DB-1:0] sqx, sqy;
    logic [SB-1:0] pair_sq;
    logic [NB:0]   sum_add;

    assign accept = start && !busy;
    assign busy   = state_reg != emst_pkg::ST_LOAD;

    always_ff @(posedge clk)
    begin
        if (pwr)
        begin
            px_mem[pwr_addr] <= points_in.x_coord;
            py_mem[pwr_addr] <= points_in.y_coord;
        end
        prd_x <= px_mem[prd_addr];
        prd_y <= py_mem[prd_addr];
    end

    // top bit of an entry: point already in the tree
    always_ff @(posedge clk)
    begin
        if (nwr)
            nd_mem[nd_addr] <= nd_wdata;
        nd_rd <= nd_mem[nd_addr];
    end

    // distance from held tree point to the point just read
    always_comb
    begin
        dx      = DB'(bx_reg) - DB'(prd_x);
        dy      = DB'(by_reg) - DB'(prd_y);
        adx     = dx[DB-1] ? DB'(-dx) : DB'(dx);
        ady     = dy[DB-1] ? DB'(-dy) : DB'(dy);
        sqx     = adx * adx;
        sqy     = ady * ady;
        pair_sq = SB'(sqx) + SB'(sqy);
    end

    emst_sqrt u_sqrt (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (sq_go),
        .sq   (best_d_reg),
        .done (sq_done),
        .root (sq_root)
    );

    assign sum_add = {1'b0, sum_reg} + (NB + 1)'(sq_root);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        drop_next   = drop_reg;
        idx_next    = idx_reg;
        added_next  = added_reg;
        best_next   = best_reg;
        best_d_next = best_d_reg;
        found_next  = found_reg;
        sum_next    = sum_reg;
        bx_next     = bx_reg;
        by_next     = by_reg;
        pwr         = 1'b0;
        pwr_addr    = count_reg[IB-1:0];
        prd_addr    = idx_reg[IB-1:0];
        nd_addr     = idx_reg[IB-1:0];
        nwr         = 1'b0;
        nd_wdata    = {1'b0, pair_sq};
        sq_go       = 1'b0;
        done        = 1'b0;
        case (state_reg)
            emst_pkg::ST_LOAD:
            begin
                prd_addr = '0;
                if (accept)
                begin
                    if (count_reg < CB'(emst_pkg::MAX_POINTS))
                    begin
                        pwr        = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else
                        drop_next = 1'b1;
                    if (points_in.last_point)
                    begin
                        sum_next   = '0;
                        added_next = CB'(1);
                        idx_next   = CB'(1);
                        // point 0 coordinates arrive next cycle
                        state_next = emst_pkg::ST_INIT_RD;
                    end
                end
            end
            emst_pkg::ST_INIT_RD:
            begin
                // prd_x holds point 0 now
                if (count_reg < CB'(2))
                    state_next = emst_pkg::ST_DONE;
                else
                begin
                    bx_next    = prd_x;
                    by_next    = prd_y;
                    state_next = emst_pkg::ST_INIT_WR;
                end
            end
            emst_pkg::ST_INIT_WR:
            begin
                // issue read of idx; the write follows via the UPD_RD and UPD_WR states
                state_next = emst_pkg::ST_UPD_RD;
            end
            emst_pkg::ST_UPD_RD:
            begin
                // read point idx and its distance
                state_next = emst_pkg::ST_UPD_WR;
            end
            emst_pkg::ST_UPD_WR:
            begin
                // first pass rewrites every entry from 1 up, which also clears its flag
                if (added_reg == CB'(1) ||
                    (!nd_rd[SB] && pair_sq < nd_rd[SB-1:0]))
                    nwr = 1'b1;
                if (idx_reg == count_reg - 1'b1)
                begin
                    idx_next   = CB'(1);
                    found_next = 1'b0;
                    state_next = (added_reg == count_reg)
                               ? emst_pkg::ST_DONE : emst_pkg::ST_SCAN_RD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = emst_pkg::ST_UPD_RD;
                end
            end
            emst_pkg::ST_SCAN_RD:
                state_next = emst_pkg::ST_SCAN_CMP;
            emst_pkg::ST_SCAN_CMP:
            begin
                if (!nd_rd[SB] && (!found_reg || nd_rd[SB-1:0] < best_d_reg))
                begin
                    found_next  = 1'b1;
                    best_next   = idx_reg[IB-1:0];
                    best_d_next = nd_rd[SB-1:0];
                end
                if (idx_reg == count_reg - 1'b1)
                    state_next = emst_pkg::ST_SQRT_GO;
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = emst_pkg::ST_SCAN_RD;
                end
            end
            emst_pkg::ST_SQRT_GO:
            begin
                sq_go      = 1'b1;
                prd_addr   = best_reg;
                // mark the chosen point as in the tree
                nd_addr    = best_reg;
                nwr        = 1'b1;
                nd_wdata   = {1'b1, best_d_reg};
                added_next = added_reg + 1'b1;
                state_next = emst_pkg::ST_SQRT_WAIT;
            end
            emst_pkg::ST_SQRT_WAIT:
            begin
                prd_addr = best_reg;
                bx_next  = prd_x;
                by_next  = prd_y;
                if (sq_done)
                begin
                    sum_next   = sum_add[NB] ? {NB{1'b1}} : sum_add[NB-1:0];
                    idx_next   = CB'(1);
                    state_next = emst_pkg::ST_UPD_RD;
                end
            end
            emst_pkg::ST_DONE:
            begin
                done       = 1'b1;
                count_next = '0;
                drop_next  = 1'b0;
                state_next = emst_pkg::ST_LOAD;
            end
            default:
                state_next = emst_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= emst_pkg::ST_LOAD;
            count_reg <= '0;
            drop_reg  <= 1'b0;
            sum_reg   <= '0;
            found_reg <= 1'b0;
            idx_reg   <= '0;
            added_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
            sum_reg   <= sum_next;
            found_reg <= found_next;
            idx_reg   <= idx_next;
            added_reg <= added_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg   <= best_next;
        best_d_reg <= best_d_next;
        bx_reg     <= bx_next;
        by_reg     <= by_next;
    end

    assign result.total_length   = (count_reg < CB'(2)) ? '0 : sum_reg;
    assign result.points_dropped = drop_reg;

    // result strobe only while busy
    assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("result strobe outside computation");
    // store never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CB'(emst_pkg::MAX_POINTS))
        else $error("point count beyond store depth");
    // after a strobe the block returns to loading with an empty store
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!busy && count_reg == '0))
        else $error("store not emptied after result");
endmodule

[hdl/emst_sqrt.sv]
// Bit-serial integer square root, one result bit per cycle.
// Depends on emst_pkg.
module emst_sqrt (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             go,
    input  logic [emst_pkg::SQ_BITS-1:0]     sq,
    output logic                             done,
    output logic [emst_pkg::ROOT_BITS-1:0]   root
);
    localparam int RB = emst_pkg::ROOT_BITS;
    localparam int CB = $clog2(RB + 1);

    logic [emst_pkg::RAD_PAD-1:0] rad_reg, rad_next;
    logic [RB+1:0]                rem_reg, rem_next;
    logic [RB-1:0]                root_reg, root_next;
    logic [CB-1:0]                cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [RB+1:0]                shifted, trial;

    always_comb
    begin
        shifted   = {rem_reg[RB-1:0], rad_reg[emst_pkg::RAD_PAD-1 -: 2]};
        trial     = {root_reg, 2'b01};
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (go)
        begin
            rad_next  = emst_pkg::RAD_PAD'({sq, {(2 * emst_pkg::FRAC_BITS){1'b0}}});
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CB'(RB);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[emst_pkg::RAD_PAD-3:0], 2'b00};
            if (shifted >= trial)
            begin
                rem_next  = shifted - trial;
                root_next = {root_reg[RB-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted;
                root_next = {root_reg[RB-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CB'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

[verif/emst_checker.sv]
// Checker for the Euclidean MST length block: watches point and result beats,
// predicts MST totals with its own dense Prim, and counts mismatches.
// Depends on emst_pkg.
module emst_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  emst_pkg::in_beat_t   points_in,
    input  logic                 done,
    input  emst_pkg::out_beat_t  result,
    output int                   fail_count,
    output int                   pending_totals
);
    localparam logic [40:0] SUM_CAP = {41{1'b1}};

    longint              px [emst_pkg::MAX_POINTS];
    longint              py [emst_pkg::MAX_POINTS];
    int                  stored_pts;
    bit                  dropped_flag;
    emst_pkg::out_beat_t expected_totals[$];

    // floor(sqrt(d2) * 2^FRAC_BITS), bitwise restoring root on a wide radicand
    function automatic logic [63:0] fixed_root(logic [63:0] d2);
        logic [127:0] rad;
        logic [127:0] rem;
        logic [127:0] root;
        logic [127:0] trial;
        rad  = {64'd0, d2} << (2 * emst_pkg::FRAC_BITS);
        rem  = '0;
        root = '0;
        for (int i = 63; i >= 0; i--) begin
            rem   = (rem << 2) | ((rad >> (2 * i)) & 128'd3);
            root  = root << 1;
            trial = (root << 1) | 128'd1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = root | 128'd1;
            end
        end
        return root[63:0];
    endfunction

    function automatic logic [63:0] dist_sq(int a, int b);
        longint dx;
        longint dy;
        dx = px[a] - px[b];
        dy = py[a] - py[b];
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        return 64'(dx * dx) + 64'(dy * dy);
    endfunction

    function automatic logic [40:0] mst_total(int n);
        bit          in_tree [emst_pkg::MAX_POINTS];
        logic [63:0] near [emst_pkg::MAX_POINTS];
        logic [63:0] acc;
        logic [63:0] d;
        int          best;
        acc = 0;
        if (n < 2)
            return '0;
        for (int i = 0; i < n; i++) in_tree[i] = 0;
        in_tree[0] = 1;
        for (int i = 1; i < n; i++) near[i] = dist_sq(0, i);
        for (int k = 1; k < n; k++) begin
            best = -1;
            for (int i = 1; i < n; i++)
                if (!in_tree[i] && (best < 0 || near[i] < near[best]))
                    best = i;
            in_tree[best] = 1;
            acc = acc + fixed_root(near[best]);
            if (acc > 64'(SUM_CAP))
                acc = 64'(SUM_CAP);
            for (int i = 1; i < n; i++)
                if (!in_tree[i])
                begin
                    d = dist_sq(best, i);
                    if (d < near[i]) near[i] = d;
                end
        end
        return acc[40:0];
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        fail_count++;
    endtask

    assign pending_totals = expected_totals.size();

    always @(posedge clk or negedge rst_n)
    begin
        emst_pkg::out_beat_t want;
        if (!rst_n)
        begin
            stored_pts   = 0;
            dropped_flag = 0;
            fail_count   = 0;
            expected_totals.delete();
        end
        else
        begin
            // result strobe first: it cannot share an edge with a point beat, as busy is high
            if (done)
            begin
                if (expected_totals.size() == 0)
                    report_mismatch("result strobe with no set closed");
                else
                begin
                    want = expected_totals.pop_front();
                    if (result.total_length !== want.total_length)
                        report_mismatch($sformatf("total_length got %0d want %0d",
                            result.total_length, want.total_length));
                    if (result.points_dropped !== want.points_dropped)
                        report_mismatch($sformatf("points_dropped got %0b want %0b",
                            result.points_dropped, want.points_dropped));
                end
            end
            if (start && !busy)
            begin
                if (stored_pts < emst_pkg::MAX_POINTS)
                begin
                    px[stored_pts] = longint'(points_in.x_coord);
                    py[stored_pts] = longint'(points_in.y_coord);
                    stored_pts++;
                end
                else
                    dropped_flag = 1;
                if (points_in.last_point)
                begin
                    want.total_length   = mst_total(stored_pts);
                    want.points_dropped = dropped_flag;
                    expected_totals = {expected_totals, want};
                    stored_pts   = 0;
                    dropped_flag = 0;
                end
            end
        end
    end
endmodule

[verif/tb.sv]
// Testbench top for euclidean_mst_length: clock, reset, point stimulus, verdict.
// Depends on emst_pkg, emst_checker and the block itself.
module tb;
    localparam longint CYCLE_LIMIT = 64'd60_000_000;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    emst_pkg::in_beat_t  points_in;
    logic                done;
    emst_pkg::out_beat_t result;
    int                  fail_count;
    int                  pending_totals;
    longint              cycles = 0;
    int                  beats_sent;
    bit                  calm_mode;

    euclidean_mst_length i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .points_in (points_in),
        .done      (done),
        .result    (result)
    );

    emst_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .points_in      (points_in),
        .done           (done),
        .result         (result),
        .fail_count     (fail_count),
        .pending_totals (pending_totals)
    );

    initial clk = 0;
    always #5 clk = ~clk;

    // watchdog on a total cycle budget for all sets plus idling
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // one beat: optional random idle, then hold start until the block takes it;
    // start stays high on return and is dropped by the next idle or the caller
    task automatic send_point(logic [15:0] x, logic [15:0] y, bit last);
        if (!calm_mode)
            while ($urandom_range(99) < 32)
            begin
                start <= 0;
                @(negedge clk);
            end
        start     <= 1;
        points_in <= '{x_coord: x, y_coord: y, last_point: last};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        beats_sent++;
        @(negedge clk);
    endtask

    // random coordinate: small values in half the draws, else full range or near the extremes
    function automatic logic [15:0] rand_coord();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return $urandom_range(1) ? 16'h7fff - 16'($urandom_range(3))
                                        : 16'h8000 + 16'($urandom_range(3));
            default: return 16'($signed(12'($urandom)));
        endcase
    endfunction

    task automatic send_set(int n);
        for (int i = 0; i < n; i++)
            send_point(rand_coord(), rand_coord(), i == n - 1);
    endtask

    initial
    begin
        int n;
        beats_sent = 0;
        calm_mode  = 0;
        rst_n      = 0;
        start      = 0;
        points_in  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: empty-ish sets, extremes, duplicates
        send_point(16'h1234, 16'h4321, 1);              // single point
        send_point(16'h8000, 16'h8000, 0);              // opposite corners
        send_point(16'h7fff, 16'h7fff, 1);
        send_point(16'h0005, 16'h0005, 0);              // coincident points
        send_point(16'h0005, 16'h0005, 1);
        send_point(16'h0000, 16'h0000, 0);              // 3-4-5 triangle
        send_point(16'h0003, 16'h0000, 0);
        send_point(16'h0000, 16'h0004, 1);
        send_point(16'h8000, 16'h7fff, 0);
        send_point(16'h7fff, 16'h8000, 0);
        send_point(16'hffff, 16'h0001, 0);
        send_point(16'h0001, 16'hffff, 1);

        // store overflow: fill, then extra points dropped, closing one too
        calm_mode = 1;
        for (int i = 0; i < emst_pkg::MAX_POINTS + 3; i++)
            send_point(16'($urandom_range(200)), 16'($urandom_range(200)),
                       i == emst_pkg::MAX_POINTS + 2);
        calm_mode = 0;

        // hold off until the block has drained everything
        start <= 0;
        while (pending_totals != 0)
            @(negedge clk);

        // random sets, mostly small to keep Prim short
        while (beats_sent < 1000)
        begin
            n = ($urandom_range(19) == 0) ? $urandom_range(40, 80)
                                          : $urandom_range(1, 12);
            calm_mode = (beats_sent > 500 && beats_sent < 650);
            send_set(n);
        end
        calm_mode = 0;

        start <= 0;
        while (pending_totals != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
